/* hw/rtl/qas_pkg.sv */
// Shared types, constants and the arcsine table for the angular speed block.
`timescale 1ns / 1ps
package qas_pkg;

  localparam int unsigned TickW  = 32;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned TabW   = 15;

  localparam logic [0:0] OpSample    = 1'b0;
  localparam logic [0:0] OpClearPeak = 1'b1;

  // One entry of the sample ring: tick count and quaternion {z,y,x,w}, w lowest
  typedef struct packed {
    logic [TickW-1:0]   tick;
    logic [4*QuatW-1:0] quat;
  } qas_sample_t;

  typedef struct packed {
    logic [0:0]  op;
    qas_sample_t sample;
  } qas_req_t;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic [SpeedW-1:0] peak;
    logic              valid;
  } qas_res_t;

  // asin(k/16)/pi in Q0.16 for k = 0..12
  function automatic logic [TabW-1:0] asin_tab(input logic [3:0] k);
    logic [TabW-1:0] t;
    unique case (k)
      4'd0:    t = 15'd0;
      4'd1:    t = 15'd1305;
      4'd2:    t = 15'd2614;
      4'd3:    t = 15'd3935;
      4'd4:    t = 15'd5271;
      4'd5:    t = 15'd6630;
      4'd6:    t = 15'd8019;
      4'd7:    t = 15'd9446;
      4'd8:    t = 15'd10923;
      4'd9:    t = 15'd12462;
      4'd10:   t = 15'd14084;
      4'd11:   t = 15'd15813;
      4'd12:   t = 15'd17691;
      default: t = 15'd17691;
    endcase
    return t;
  endfunction

endpackage

/* hw/rtl/qas_ring.sv */
// Sample ring memory: one write port, one registered read port.
`timescale 1ns / 1ps
module qas_ring #(
  parameter int unsigned WINDOW = 5
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [$clog2(WINDOW)-1:0] waddr_i,
  input  qas_pkg::qas_sample_t      wdata_i,
  input  logic [$clog2(WINDOW)-1:0] raddr_i,
  output qas_pkg::qas_sample_t      rdata_o
);
  import qas_pkg::*;

  qas_sample_t mem_q [WINDOW];
  qas_sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/qas_core.sv */
// Sequencer and shared multiplier / shift-subtract datapath for one sample.
`timescale 1ns / 1ps
module qas_core #(
  parameter int unsigned WINDOW = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  qas_pkg::qas_req_t        req_i,
  input  logic [15:0]              tps_i,
  output logic                     idle_o,
  output logic                     res_valid_o,
  input  logic                     res_take_i,
  output qas_pkg::qas_res_t        res_o
);
  import qas_pkg::*;

  localparam int unsigned IdxW = $clog2(WINDOW);
  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam int unsigned AccW = 35;
  localparam int unsigned NqW  = 23;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(WINDOW - 1);
  localparam logic [CntW-1:0] Full     = CntW'(WINDOW);
  localparam logic signed [AccW-1:0] OneQ28 = AccW'(64'sd268435456);

  typedef enum logic [3:0] {
    StIdle, StDt, StMul, StClamp, StSqrt, StInterp, StScale, StNum, StDiv, StFin, StDone
  } state_e;

  state_e            state_q;
  logic [IdxW-1:0]   ws_q;
  logic [CntW-1:0]   fill_q;
  logic [SpeedW-1:0] cur_q, peak_q;
  qas_res_t          res_q;
  qas_sample_t       new_q;
  logic [4*QuatW-1:0] old_q;
  logic              same_q, neg_q;
  logic [TickW-1:0]  dt_q;
  logic signed [AccW-1:0] acc_q;
  logic [4:0]        cnt_q;
  logic [31:0]       v_q, res_sq_q, bit_q;
  logic [16:0]       a_q;
  logic [32:0]       prod_q;
  logic [NqW-1:0]    quo_q;
  logic [32:0]       rem_q;

  // slot bookkeeping for an incoming sample
  logic [IdxW-1:0] ws_next, old_idx;
  logic [CntW-1:0] fill_next;
  qas_sample_t     rdata;

  always_comb begin
    ws_next   = (ws_q == LastSlot) ? '0 : ws_q + 1'b1;
    fill_next = (fill_q < Full) ? fill_q + 1'b1 : fill_q;
    old_idx   = (fill_next >= Full) ? ws_next : '0;
  end

  qas_ring #(.WINDOW(WINDOW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (start_i && state_q == StIdle && req_i.op == OpSample),
    .waddr_i (ws_q),
    .wdata_i (req_i.sample),
    .raddr_i (old_idx),
    .rdata_o (rdata)
  );

  // shared multiplier
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] mul_p;
  logic [15:0]        qn, qo;

  // interpolation operands
  logic [15:0]     s_val;
  logic [3:0]      ti;
  logic [11:0]     tf;
  logic [TabW-1:0] t0, t1, tdiff;
  logic [16:0]     h;
  logic [16:0]     a_val;

  always_comb begin
    qn    = new_q.quat[cnt_q[1:0]*QuatW +: QuatW];
    qo    = old_q[cnt_q[1:0]*QuatW +: QuatW];
    s_val = res_sq_q[15:0];
    if (s_val[15:12] > 4'd11) begin
      ti = 4'd11;
      tf = 12'hfff;
    end else begin
      ti = s_val[15:12];
      tf = s_val[11:0];
    end
    t0    = asin_tab(ti);
    t1    = asin_tab(ti + 4'd1);
    tdiff = t1 - t0;
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StMul: begin
        mul_a = {{2{qn[15]}}, qn};
        mul_b = {{2{qo[15]}}, qo};
      end
      StInterp: begin
        mul_a = {3'b0, tdiff};
        mul_b = {6'b0, tf};
      end
      StScale: begin
        mul_a = {2'b0, tps_i};
        mul_b = {1'b0, a_q};
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
    h     = {2'b0, t0} + 17'((mul_p[23:0] + 24'd2048) >> 12);
    a_val = neg_q ? 17'h10000 - {h[15:0], 1'b0} : {h[15:0], 1'b0};
  end

  // clamp, sqrt step, divide step, numerator and tick difference
  logic signed [AccW-1:0] acc_cl;
  logic [28:0]            mag;
  logic [31:0]            sq_trial;
  logic                   sq_ge;
  logic [32:0]            rem_sh;
  logic                   div_ge;
  logic [38:0]            num;
  logic [TickW-1:0]       dt_now;

  always_comb begin
    if (acc_q > OneQ28)       acc_cl = OneQ28;
    else if (acc_q < -OneQ28) acc_cl = -OneQ28;
    else                      acc_cl = acc_q;
    mag      = acc_cl[AccW-1] ? 29'(-acc_cl) : 29'(acc_cl);
    sq_trial = res_sq_q + bit_q;
    sq_ge    = v_q >= sq_trial;
    rem_sh   = {rem_q[31:0], quo_q[NqW-1]};
    div_ge   = rem_sh >= {1'b0, dt_q};
    num      = ({6'b0, prod_q} << 6) - ({6'b0, prod_q} << 2);
    dt_now   = new_q.tick - rdata.tick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ws_q    <= '0;
      fill_q  <= '0;
      cur_q   <= '0;
      peak_q  <= '0;
      same_q  <= 1'b0;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            new_q <= req_i.sample;
            if (req_i.op == OpClearPeak) begin
              peak_q  <= '0;
              res_q   <= '{speed: cur_q, peak: '0, valid: 1'b0};
              state_q <= StDone;
            end else begin
              ws_q    <= ws_next;
              fill_q  <= fill_next;
              // first sample reads its own slot: no difference yet
              same_q  <= (old_idx == ws_q);
              state_q <= StDt;
            end
          end
        end
        StDt: begin
          if (same_q || dt_now == '0) begin
            res_q   <= '{speed: cur_q, peak: peak_q, valid: 1'b0};
            state_q <= StDone;
          end else begin
            dt_q    <= dt_now;
            old_q   <= rdata.quat;
            acc_q   <= '0;
            cnt_q   <= '0;
            state_q <= StMul;
          end
        end
        StMul: begin
          acc_q <= acc_q + AccW'(mul_p);
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd3) begin
            state_q <= StClamp;
          end
        end
        StClamp: begin
          neg_q    <= acc_cl[AccW-1];
          v_q      <= {3'b0, 29'h1000_0000 - mag} << 3;
          res_sq_q <= '0;
          bit_q    <= 32'h4000_0000;
          cnt_q    <= '0;
          state_q  <= StSqrt;
        end
        StSqrt: begin
          if (sq_ge) begin
            v_q      <= v_q - sq_trial;
            res_sq_q <= (res_sq_q >> 1) + bit_q;
          end else begin
            res_sq_q <= res_sq_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd15) begin
            state_q <= StInterp;
          end
        end
        StInterp: begin
          a_q     <= a_val;
          state_q <= StScale;
        end
        StScale: begin
          prod_q  <= mul_p[32:0];
          state_q <= StNum;
        end
        StNum: begin
          quo_q   <= num[38:16];
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          rem_q <= div_ge ? rem_sh - {1'b0, dt_q} : rem_sh;
          quo_q <= {quo_q[NqW-2:0], div_ge};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(NqW - 1)) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          logic [SpeedW-1:0] sp;
          sp      = (quo_q > NqW'(16'hffff)) ? 16'hffff : quo_q[SpeedW-1:0];
          cur_q   <= sp;
          peak_q  <= (sp > peak_q) ? sp : peak_q;
          res_q   <= '{speed: sp, peak: (sp > peak_q) ? sp : peak_q, valid: 1'b1};
          state_q <= StDone;
        end
        StDone: begin
          if (res_take_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign idle_o      = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);
  assign res_o       = res_q;

endmodule

/* hw/rtl/quaternion_angular_speed.sv */
// Top level: stream ports, rate register and output register around the core.
`timescale 1ns / 1ps
//  channel  | direction | content
//  s_axis   | in        | tdata: frame_count, quat_w, quat_x, quat_y, quat_z; tuser: op
//  m_axis   | out       | tdata: speed_rpm, peak_rpm; tuser: speed_valid
//  cfg      | in        | ticks_per_second, written whenever cfg_we_i is high
//
//  A sample passes through the 16-step square root and the 23-step divide of
//  the shift-subtract sequencer; a zero tick difference or a peak clear skips
//  that arithmetic. s_axis_tready is high while the core is idle; one finished
//  item waits in the output register. Reset clears the ring pointers, speed,
//  peak and sets ticks_per_second to 60.
module quaternion_angular_speed #(
  parameter int unsigned WINDOW = 5
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // frame_count, quat_w, quat_x, quat_y, quat_z
  input  logic [0:0]   s_axis_tuser,   // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // speed_rpm, peak_rpm
  output logic [0:0]   m_axis_tuser,   // speed_valid
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);
  import qas_pkg::*;

  logic [15:0] tps_q;
  logic        core_idle, res_valid, res_take, out_valid_q;
  qas_req_t    req;
  qas_res_t    res, out_q;

  assign req.op          = s_axis_tuser;
  assign req.sample.tick = s_axis_tdata[31:0];
  assign req.sample.quat = s_axis_tdata[95:32];

  assign s_axis_tready = core_idle;
  assign res_take      = res_valid && (!out_valid_q || m_axis_tready);

  qas_core #(.WINDOW(WINDOW)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid && core_idle),
    .req_i       (req),
    .tps_i       (tps_q),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q       <= 16'd60;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.peak, out_q.speed};
  assign m_axis_tuser  = out_q.valid;

endmodule

/* dv/quaternion_angular_speed_test.sv */
// Self-checking testbench for the quaternion angular speed block.
`timescale 1ns / 1ps
module quaternion_angular_speed_test;
  import qas_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  // Tracks ring, speed, peak and rate; keeps expected results in arrival order
  class speed_scoreboard;
    logic [31:0] ticks [5];
    logic [63:0] quats [5];
    int unsigned wr_slot, fill;
    logic [15:0] cur_speed, peak_speed, tps;
    qas_res_t    speed_q [$];
    int unsigned errors;

    function new();
      wr_slot = 0; fill = 0; cur_speed = 0; peak_speed = 0; tps = 16'd60; errors = 0;
      foreach (ticks[k]) begin
        ticks[k] = '0;
        quats[k] = '0;
      end
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
        if (v >= res + bit_v) begin
          v -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    // acos(d / 2^28) / pi in Q0.16
    function longint unsigned acos_frac(longint d);
      longint unsigned asin_pts [13] = '{0, 1305, 2614, 3935, 5271, 6630, 8019,
                                         9446, 10923, 12462, 14084, 15813, 17691};
      longint unsigned m, s, i, f, h;
      m = (d < 0) ? -d : d;
      s = int_sqrt(((64'd1 << 28) - m) << 3);
      i = s >> 12;
      f = s & 4095;
      if (i > 11) begin
        i = 11;
        f = 4095;
      end
      h = asin_pts[i] + (((asin_pts[i+1] - asin_pts[i]) * f + 2048) >> 12);
      return (d < 0) ? 65536 - 2 * h : 2 * h;
    endfunction

    function void note_item(logic op, logic [31:0] tick, logic [63:0] q);
      qas_res_t exp_r;
      int unsigned old;
      logic [31:0] dt;
      longint d, a, sp;
      exp_r.valid = 1'b0;
      if (op == OpClearPeak) begin
        peak_speed = 0;
      end else begin
        ticks[wr_slot] = tick;
        quats[wr_slot] = q;
        wr_slot = (wr_slot + 1) % 5;
        if (fill < 5) fill++;
        old = (fill >= 5) ? wr_slot : 0;
        dt = tick - ticks[old];
        if (dt != 0) begin
          d = 0;
          for (int k = 0; k < 4; k++)
            d += longint'($signed(q[16*k +: 16])) * longint'($signed(quats[old][16*k +: 16]));
          if (d > (64'sd1 <<< 28)) d = 64'sd1 <<< 28;
          if (d < -(64'sd1 <<< 28)) d = -(64'sd1 <<< 28);
          a = acos_frac(d);
          sp = (60 * longint'(tps) * a) / (longint'(dt) << 16);
          if (sp > 65535) sp = 65535;
          cur_speed = sp[15:0];
          if (cur_speed > peak_speed) peak_speed = cur_speed;
          exp_r.valid = 1'b1;
        end
      end
      exp_r.speed = cur_speed;
      exp_r.peak  = peak_speed;
      speed_q.insert(speed_q.size(), exp_r);
    endfunction

    function void check_result(qas_res_t got);
      qas_res_t exp_r;
      if (speed_q.size() == 0) begin
        $display("%0t: unexpected result speed=%0d peak=%0d valid=%0d",
                 $time, got.speed, got.peak, got.valid);
        errors++;
        return;
      end
      exp_r = speed_q[0];
      speed_q.delete(0);
      if (got.speed !== exp_r.speed) begin
        $display("%0t: speed_rpm expected %0d actual %0d", $time, exp_r.speed, got.speed);
        errors++;
      end
      if (got.peak !== exp_r.peak) begin
        $display("%0t: peak_rpm expected %0d actual %0d", $time, exp_r.peak, got.peak);
        errors++;
      end
      if (got.valid !== exp_r.valid) begin
        $display("%0t: speed_valid expected %0d actual %0d", $time, exp_r.valid, got.valid);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = 16'd60;

  speed_scoreboard sb = new();
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  logic [31:0] cur_tick = 32'd1000;
  logic signed [15:0] qw = 16'sd16384, qx = 0, qy = 0, qz = 0;

  always #4 clk_i = ~clk_i;

  quaternion_angular_speed #(.WINDOW(5)) i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .cfg_we_i, .cfg_wdata_i
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: check, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_result('{speed: m_axis_tdata[15:0], peak: m_axis_tdata[31:16],
                        valid: m_axis_tuser[0]});
    if (hold_req && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rst_ni && idle_en && $urandom_range(0, 99) < 12);
    end
  end

  task automatic send(logic op, logic [31:0] tick, logic [15:0] w, logic [15:0] x,
                      logic [15:0] y, logic [15:0] z);
    if (idle_en && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {z, y, x, w, tick};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, tick, {w, x, y, z});
  endtask

  task automatic sample(logic [31:0] tick, logic [15:0] w, logic [15:0] x,
                        logic [15:0] y, logic [15:0] z);
    send(OpSample, tick, w, x, y, z);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.speed_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_rate(logic [15:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.tps = v;
  endtask

  function automatic logic signed [15:0] nudge(logic signed [15:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 600)) - 300;
    if (t > 16384) t = 16384;
    if (t < -16384) t = -16384;
    return t[15:0];
  endfunction

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send(OpClearPeak, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
           16'($urandom));
    end else if (r < 16) begin
      sample($urandom, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      // smooth rotation: small quaternion moves; tick steps mostly small, some zero or random
      if (r < 22) cur_tick = cur_tick + $urandom;
      else if (r < 30) cur_tick = cur_tick;
      else cur_tick = cur_tick + $urandom_range(1, 4);
      qw = nudge(qw); qx = nudge(qx); qy = nudge(qy); qz = nudge(qz);
      sample(cur_tick, qw, qx, qy, qz);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first sample, then repeated tick, opposite signs, clamp, wrap
    sample(32'd100, 16'sd16384, 0, 0, 0);
    sample(32'd100, 16'sd16384, 0, 0, 0);
    sample(32'd101, 0, 16'sd16384, 0, 0);
    sample(32'd102, -16'sd16384, 0, 0, 0);
    send(OpClearPeak, 0, 0, 0, 0, 0);
    sample(32'd103, 0, -16'sd16384, 0, 0);
    sample(32'd104, 0, 0, 16'sd16384, 0);
    sample(32'd105, 0, 0, 0, -16'sd16384);
    sample(32'd106, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    sample(32'hffff_ffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    sample(32'd3, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    sample(32'd4, 16'sd16384, 0, 0, 0);
    send(OpClearPeak, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    sample(32'd4, 16'sd11585, 16'sd11585, 0, 0);
    set_rate(16'd65535);
    sample(32'd5, 0, 0, 16'sd16384, 0);
    sample(32'd6, 16'sd16384, 0, 0, 0);
    sample(32'd7, -16'sd16384, 0, 0, 0);
    set_rate(16'd1);
    sample(32'd8, 16'sd16384, 0, 0, 0);
    sample(32'd9, 0, 0, 0, 16'sd16384);

    for (int n = 0; n < 1100; n++) begin
      if (n % 220 == 0) begin
        case ($urandom_range(0, 3))
          0: set_rate(16'd60);
          1: set_rate(16'd1);
          2: set_rate(16'd65535);
          default: set_rate(16'($urandom_range(1, 65535)));
        endcase
      end
      if (n == 300) hold_req = 1'b1;
      if (n == 400) idle_en = 1'b0;
      if (n == 650) idle_en = 1'b1;
      if (n == 800) drain();
      random_item();
    end

    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
